/* rtl/core/trz_pkg.sv */
`default_nettype none
package trz_pkg;
    localparam int MAX_WIDTH_DEF  = 640;
    localparam int MAX_HEIGHT_DEF = 480;
    localparam int DEPTH_BITS_DEF = 20;

    typedef enum logic [1:0] {
        MODE_DRAW  = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WIPE,
        S_RD0,
        S_RD1,
        S_AREA0,
        S_AREA1,
        S_AREA2,
        S_BOX,
        S_PIX,
        S_E0,
        S_E1,
        S_E2,
        S_M0,
        S_M1,
        S_M2,
        S_DIV,
        S_DEP,
        S_WR,
        S_DONE
    } t_state;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;
endpackage
`default_nettype wire

/* rtl/core/trz_div.sv */
`default_nettype none
module trz_div #(
    parameter int NW = 64,
    parameter int DW = 40
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_run, n_run;
    logic [DW:0]   w_sh;

    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_run = r_run;
        w_sh  = {r_rem[DW-1:0], r_q[NW-1]};
        if (i_go) begin
            n_q   = i_num;
            n_rem = '0;
            n_cnt = CW'(NW);
            n_run = 1'b1;
        end else if (r_run) begin
            if (w_sh >= {1'b0, i_den}) begin
                n_rem = w_sh - {1'b0, i_den};
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) n_run = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (!i_rst_n) r_run <= 1'b0;
        else          r_run <= n_run;
    end

    assign o_done = r_run && (r_cnt == CW'(1));
    assign o_quo  = n_q;
endmodule
`default_nettype wire

/* rtl/core/triangle_raster_zbuffer.sv */
`default_nettype none
// Depth-tested triangle rasterizer with on-chip depth and color stores.
// Command channel: i_start with the item fields is taken when o_busy is low.
// Each item returns exactly one result: o_done pulses for one cycle with
// o_pixel_color and o_pixels_written; the receiver cannot stall.
// Configuration: APB writes to screen_width (0x0) and screen_height (0x4).
// Mode 1 (clear) sweeps all MAX_WIDTH * MAX_HEIGHT entries of both stores,
// one entry per cycle. Reset runs the same clearing pass; o_busy is high for
// that time and no item is taken.
// Mode 2 (read) answers after S_RD0 and S_RD1; mode 3 answers from idle.
// Mode 0 (draw): setup in S_AREA0..S_AREA2 (area), then S_BOX (clipped box); a
// zero area stops after S_AREA2. Per pixel of the clipped bounding box, outside
// the triangle: S_PIX, S_E0, S_E1, S_E2, S_M0, S_DEP; inside: S_PIX to S_M2
// compute edge values w0, w1 and depth products on the shared multiplier (one
// product per cycle), S_DIV runs the bit-serial divider (one quotient bit per
// cycle), S_WR and S_DEP do depth test and step. S_DONE closes the item and the
// result shows in the cycle after it.
module triangle_raster_zbuffer
    import trz_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_mode,
    input  wire logic signed [15:0] i_vertex_a_x,
    input  wire logic signed [15:0] i_vertex_a_y,
    input  wire logic signed [19:0] i_vertex_a_depth,
    input  wire logic signed [15:0] i_vertex_b_x,
    input  wire logic signed [15:0] i_vertex_b_y,
    input  wire logic signed [19:0] i_vertex_b_depth,
    input  wire logic signed [15:0] i_vertex_c_x,
    input  wire logic signed [15:0] i_vertex_c_y,
    input  wire logic signed [19:0] i_vertex_c_depth,
    input  wire logic [23:0] i_fill_color,
    input  wire logic [18:0] i_read_index,
    output logic             o_done,
    output logic [23:0]      o_pixel_color,
    output logic [18:0]      o_pixels_written,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = $clog2(SIZE + 1);
    localparam int XW   = $clog2(MAX_WIDTH + 1);
    localparam int YW   = $clog2(MAX_HEIGHT + 1);
    localparam logic signed [DEPTH_BITS-1:0] FAR = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] NEAR = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam int NW = 64;
    localparam int DW = 36;

    logic [DEPTH_BITS-1:0] r_zmem [SIZE];
    logic [23:0]           r_cmem [SIZE];

    t_state r_state, n_state;
    logic [9:0]  r_sw;
    logic [8:0]  r_sh;
    logic signed [15:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic signed [19:0] r_z0, r_z1, r_z2;
    logic [23:0] r_col;
    logic [18:0] r_ridx;
    logic [AW-1:0] r_wp, n_wp;
    logic [XW-1:0] r_x, n_x, r_lox, n_lox, r_hix, n_hix;
    logic [YW-1:0] r_y, n_y, r_hiy, n_hiy;
    logic [AW-1:0] r_row, n_row;
    logic signed [35:0] r_area, n_area;
    logic signed [67:0] r_acc, n_acc;
    logic signed [35:0] r_w0, n_w0, r_w1, n_w1, r_w2, n_w2;
    logic        r_neg, n_neg;
    logic [18:0] r_cnt, n_cnt;
    logic signed [DEPTH_BITS-1:0] r_pz, n_pz, r_old;
    logic [23:0] r_rd;
    logic [23:0] n_oc;
    logic [18:0] n_ow;
    logic        n_done;

    logic signed [33:0] m_a, m_b;
    logic signed [67:0] m_p;
    assign m_p = m_a * m_b;

    logic        dv_go, dv_done;
    logic [NW-1:0] dv_num, dv_quo;
    trz_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(dv_go), .i_num(dv_num),
        .i_den(r_area[DW-1:0]), .o_done(dv_done), .o_quo(dv_quo)
    );

    logic [10:0] w_wc;
    logic [9:0]  w_hc;
    assign w_wc = (r_sw > 10'(MAX_WIDTH > 1023 ? 1023 : MAX_WIDTH))
                ? 11'(MAX_WIDTH) : {1'b0, r_sw};
    assign w_hc = (r_sh > 9'(MAX_HEIGHT > 511 ? 511 : MAX_HEIGHT))
                ? 10'(MAX_HEIGHT) : {1'b0, r_sh};

    logic signed [17:0] px, py;
    assign px = $signed({1'b0, 13'(r_x), 4'd8});
    assign py = $signed({1'b0, 13'(r_y), 4'd8});

    logic signed [67:0] w_abs;
    logic signed [15:0] mnx, mny, mxx, mxy;
    logic [AW-1:0] w_idx;
    assign w_idx = r_row + AW'(r_x);

    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_HEIGHT) prdata = {23'd0, r_sh};
        else                        prdata = {22'd0, r_sw};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= 10'd640;
            r_sh <= 9'd480;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_HEIGHT) r_sh <= pwdata[8:0];
            else                        r_sw <= pwdata[9:0];
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state; n_wp = r_wp; n_x = r_x; n_y = r_y; n_lox = r_lox;
        n_hix = r_hix; n_hiy = r_hiy; n_row = r_row; n_area = r_area;
        n_acc = r_acc; n_w0 = r_w0; n_w1 = r_w1; n_w2 = r_w2; n_neg = r_neg;
        n_cnt = r_cnt; n_pz = r_pz; n_oc = '0; n_ow = '0; n_done = 1'b0;
        m_a = '0; m_b = '0; dv_go = 1'b0; dv_num = '0; w_abs = '0;
        mnx = '0; mny = '0; mxx = '0; mxy = '0;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                unique case (t_mode'(i_mode))
                    MODE_DRAW:  n_state = S_AREA0;
                    MODE_CLEAR: begin n_state = S_WIPE; n_wp = '0; end
                    MODE_READ:  n_state = S_RD0;
                    default:    begin n_done = 1'b1; end
                endcase
                n_cnt = '0;
            end
            S_WIPE: begin
                n_wp = r_wp + 1'b1;
                if (r_wp == AW'(SIZE - 1)) begin
                    n_state = S_IDLE;
                    n_done = r_cnt[0];
                end
            end
            S_RD0: n_state = S_RD1;
            S_RD1: begin
                n_done = 1'b1;
                n_oc = ({13'd0, r_ridx} < 32'(SIZE)) ? r_rd : 24'd0;
                n_state = S_IDLE;
            end
            S_AREA0: begin
                m_a = 34'(r_x2) - 34'(r_x0); m_b = 34'(r_y1) - 34'(r_y0);
                n_acc = m_p; n_state = S_AREA1;
            end
            S_AREA1: begin
                m_a = 34'(r_y2) - 34'(r_y0); m_b = 34'(r_x1) - 34'(r_x0);
                n_acc = r_acc - m_p; n_state = S_AREA2;
            end
            S_AREA2: begin
                n_neg  = r_acc < 0;
                w_abs  = r_acc < 0 ? -r_acc : r_acc;
                n_area = w_abs[35:0];
                n_state = (r_acc == 0) ? S_DONE : S_BOX;
            end
            S_BOX: begin
                mnx = (r_x0 < r_x1) ? r_x0 : r_x1; mnx = (mnx < r_x2) ? mnx : r_x2;
                mny = (r_y0 < r_y1) ? r_y0 : r_y1; mny = (mny < r_y2) ? mny : r_y2;
                mxx = (r_x0 > r_x1) ? r_x0 : r_x1; mxx = (mxx > r_x2) ? mxx : r_x2;
                mxy = (r_y0 > r_y1) ? r_y0 : r_y1; mxy = (mxy > r_y2) ? mxy : r_y2;
                if (mxx < 0 || mxy < 0 || w_wc == 0 || w_hc == 0) begin
                    n_state = S_DONE;
                end else begin
                    n_lox = mnx < 0 ? '0 : ((13'(mnx >>> 4) > 13'(MAX_WIDTH))
                        ? XW'(MAX_WIDTH) : XW'(mnx >>> 4));
                    n_hix = (12'(mxx >>> 4) > 12'(w_wc - 1'b1))
                        ? XW'(w_wc - 1'b1) : XW'(mxx >>> 4);
                    n_y   = mny < 0 ? '0 : ((13'(mny >>> 4) > 13'(MAX_HEIGHT))
                        ? YW'(MAX_HEIGHT) : YW'(mny >>> 4));
                    n_hiy = (12'(mxy >>> 4) > 12'(w_hc - 1'b1))
                        ? YW'(w_hc - 1'b1) : YW'(mxy >>> 4);
                    n_row = AW'(AW'(n_y) * AW'(w_wc));
                    n_x = n_lox;
                    n_state = (n_y > n_hiy || n_lox > n_hix) ? S_DONE : S_PIX;
                end
            end
            S_PIX: begin
                m_a = 34'(px - r_x1); m_b = 34'(r_y2) - 34'(r_y1);
                n_acc = m_p; n_state = S_E0;
            end
            S_E0: begin
                m_a = 34'(py - r_y1); m_b = 34'(r_x2) - 34'(r_x1);
                n_w0 = 36'(r_acc - m_p);
                m_a = m_a; n_state = S_E1;
            end
            S_E1: begin
                m_a = 34'(px - r_x2); m_b = 34'(r_y0) - 34'(r_y2);
                n_acc = m_p;
                n_w0 = r_neg ? -r_w0 : r_w0;
                n_state = S_E2;
            end
            S_E2: begin
                m_a = 34'(py - r_y2); m_b = 34'(r_x0) - 34'(r_x2);
                n_w1 = r_neg ? -36'(r_acc - m_p) : 36'(r_acc - m_p);
                n_state = S_M0;
            end
            S_M0: begin
                // edge w2 from area identity: w2 = |area| - w0 - w1
                n_w2 = r_area - r_w0 - r_w1;
                if (r_w0 < 0 || r_w1 < 0 || n_w2 < 0) n_state = S_DEP;
                else n_state = S_M1;
                m_a = 34'(r_w0); m_b = 34'(r_z0);
                n_acc = m_p;
            end
            S_M1: begin
                m_a = 34'(r_w1); m_b = 34'(r_z1);
                n_acc = r_acc + m_p; n_state = S_M2;
            end
            S_M2: begin
                m_a = 34'(r_w2); m_b = 34'(r_z2);
                w_abs = r_acc + m_p;
                n_acc = w_abs;
                dv_go = 1'b1;
                dv_num = w_abs < 0 ? NW'(-w_abs) : NW'(w_abs);
                n_state = S_DIV;
            end
            S_DIV: if (dv_done) begin
                w_abs = r_acc < 0 ? -$signed({4'd0, dv_quo}) : $signed({4'd0, dv_quo});
                if (w_abs > 68'(FAR)) n_pz = FAR;
                else if (w_abs < 68'(NEAR)) n_pz = NEAR;
                else n_pz = DEPTH_BITS'(w_abs);
                n_state = S_WR;
            end
            S_WR: begin
                if ({1'b0, w_idx} < (AW+1)'(SIZE) && r_pz < r_old) n_cnt = r_cnt + 1'b1;
                n_state = S_DEP;
            end
            S_DEP: begin
                if (r_x == r_hix) begin
                    n_x = r_lox;
                    if (r_y == r_hiy) n_state = S_DONE;
                    else begin
                        n_y = r_y + 1'b1;
                        n_row = r_row + AW'(w_wc);
                        n_state = S_PIX;
                    end
                end else begin
                    n_x = r_x + 1'b1;
                    n_state = S_PIX;
                end
            end
            S_DONE: begin
                n_done = 1'b1; n_ow = r_cnt; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
            r_wp    <= '0;
            r_cnt   <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_cnt   <= (r_state == S_IDLE && i_start && t_mode'(i_mode) == MODE_CLEAR)
                       ? 19'd1 : n_cnt;
            o_done  <= n_done;
        end
        o_pixel_color    <= n_oc;
        o_pixels_written <= n_done ? n_ow : '0;
        r_x <= n_x; r_y <= n_y; r_lox <= n_lox; r_hix <= n_hix; r_hiy <= n_hiy;
        r_row <= n_row; r_area <= n_area; r_acc <= n_acc; r_w0 <= n_w0;
        r_w1 <= n_w1; r_w2 <= n_w2; r_neg <= n_neg; r_pz <= n_pz;
        if (r_state == S_IDLE && i_start) begin
            r_x0 <= i_vertex_a_x; r_y0 <= i_vertex_a_y; r_z0 <= i_vertex_a_depth;
            r_x1 <= i_vertex_b_x; r_y1 <= i_vertex_b_y; r_z1 <= i_vertex_b_depth;
            r_x2 <= i_vertex_c_x; r_y2 <= i_vertex_c_y; r_z2 <= i_vertex_c_depth;
            r_col <= i_fill_color; r_ridx <= i_read_index;
        end
    end

    always_ff @(posedge i_clk) begin
        r_old <= r_zmem[w_idx[AW-1:0] < AW'(SIZE) ? w_idx : '0];
        r_rd  <= r_cmem[({13'd0, r_ridx} < 32'(SIZE)) ? AW'(r_ridx) : '0];
        if (r_state == S_WIPE) begin
            r_zmem[r_wp] <= FAR;
            r_cmem[r_wp] <= '0;
        end else if (r_state == S_WR && {1'b0, w_idx} < (AW+1)'(SIZE)
                     && r_pz < r_old) begin
            r_zmem[w_idx] <= r_pz;
            r_cmem[w_idx] <= r_col;
        end
    end
endmodule
`default_nettype wire
